FILE: rtl/core/mhdm_pkg.sv
// ----------------------------------------------------------------------------
// mhdm_pkg
// Shared field widths, stream layout and request codes for the max-heap
// extract-max block.
// ----------------------------------------------------------------------------
package mhdm_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int CNT_W  = 7;
    localparam int MODE_W = 2;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_APPEND = 2'd0;
    localparam mode_t MODE_DELETE = 2'd1;
    localparam mode_t MODE_READ   = 2'd2;

endpackage

FILE: rtl/core/max_heap_delete_max.sv
// ----------------------------------------------------------------------------
// max_heap_delete_max
// Binary max-heap of signed 32-bit entries held in a synchronous RAM.
// Append (no sift), extract-max with sift-down, and read at a position.
//
//   channel  dir  tdata                              tuser
//   s_       in   [6:0] position, [38:7] value      [1:0] mode
//   m_       out  [31:0] data, [38:32] count        [0] flag
//
// Append and rejected requests finish directly; a read first waits on the RAM.
// Extract-max reads the root and the last entry, then sifts the last entry
// down a level per child read and compare until a leaf or a compare stops it.
// Synchronous active-low reset clears the count; RAM contents are not reset.
// A finished result waits in the output register while the next request
// is taken; the block stalls only when a new result finds that register full.
// ----------------------------------------------------------------------------
module max_heap_delete_max #(
    parameter int DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mhdm_pkg::S_TDATA_W-1:0] s_tdata,   // position, value
    input  logic [mhdm_pkg::MODE_W-1:0]    s_tuser,   // mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mhdm_pkg::M_TDATA_W-1:0] m_tdata,   // data, count
    output logic                           m_tuser    // flag
);
    import mhdm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RDW  = 3'd1;
    localparam logic [2:0] ST_DEL  = 3'd2;
    localparam logic [2:0] ST_SRD  = 3'd3;
    localparam logic [2:0] ST_SCMP = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic signed [DATA_W-1:0] heap_mem [DEPTH];
    logic signed [DATA_W-1:0] mem_qa_reg, mem_qb_reg;

    logic [2:0]               state_reg, state_next;
    logic [PW-1:0]            count_reg, count_next;
    logic [PW-1:0]            cur_reg, cur_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] res_data_reg, res_data_next;
    logic                     res_flag_reg, res_flag_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_data_reg, m_data_next;
    logic [CNT_W-1:0]         m_count_reg, m_count_next;
    logic                     m_flag_reg, m_flag_next;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [AW-1:0]            rd_addr_a, rd_addr_b;

    logic                     s_hs;
    mode_t                    in_mode;
    logic [POS_W-1:0]         in_pos;
    logic signed [DATA_W-1:0] in_val;
    logic                     full, empty, pos_ok;
    logic [PW:0]              l_pos, r_pos, n_ext, best_pos;
    logic                     pick_r;
    logic signed [DATA_W-1:0] child;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_hs     = s_tvalid & s_tready;
    assign in_mode  = s_tuser;
    assign in_pos   = s_tdata[POS_W-1:0];
    assign in_val   = s_tdata[POS_W +: DATA_W];

    assign full   = (count_reg == PW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign pos_ok = (in_pos != '0) &&
                    ({{PW{1'b0}}, in_pos} <= {{POS_W{1'b0}}, count_reg});

    assign l_pos    = {cur_reg, 1'b0};
    assign r_pos    = l_pos + 1'b1;
    assign n_ext    = {1'b0, count_reg};
    assign pick_r   = (r_pos <= n_ext) && (mem_qb_reg > mem_qa_reg);
    assign child    = pick_r ? mem_qb_reg : mem_qa_reg;
    assign best_pos = pick_r ? r_pos : l_pos;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        val_next      = val_reg;
        res_data_next = res_data_reg;
        res_flag_next = res_flag_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_count_next  = m_count_reg;
        m_flag_next   = m_flag_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = val_reg;
        rd_addr_a     = '0;
        rd_addr_b     = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_hs) begin
                    res_data_next = '0;
                    res_flag_next = 1'b1;
                    state_next    = ST_FIN;
                    case (in_mode)
                        MODE_APPEND: begin
                            if (!full) begin
                                wr_en         = 1'b1;
                                wr_addr       = count_reg[AW-1:0];
                                wr_data       = in_val;
                                count_next    = count_reg + 1'b1;
                                res_flag_next = 1'b0;
                            end
                        end
                        MODE_DELETE: begin
                            if (!empty) begin
                                rd_addr_a     = '0;
                                rd_addr_b     = AW'(count_reg - 1'b1);
                                count_next    = count_reg - 1'b1;
                                res_flag_next = 1'b0;
                                state_next    = ST_DEL;
                            end
                        end
                        MODE_READ: begin
                            if (pos_ok) begin
                                rd_addr_a     = AW'(in_pos - 1'b1);
                                res_flag_next = 1'b0;
                                state_next    = ST_RDW;
                            end
                        end
                        default: begin
                            res_flag_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RDW: begin
                res_data_next = mem_qa_reg;
                state_next    = ST_FIN;
            end
            ST_DEL: begin
                res_data_next = mem_qa_reg;
                val_next      = mem_qb_reg;
                cur_next      = PW'(1);
                state_next    = ST_SRD;
            end
            ST_SRD: begin
                if (l_pos > n_ext) begin
                    // leaf reached: park the moving entry here
                    wr_en      = 1'b1;
                    wr_addr    = AW'(cur_reg - 1'b1);
                    wr_data    = val_reg;
                    state_next = ST_FIN;
                end else begin
                    rd_addr_a  = AW'(l_pos - 1'b1);
                    rd_addr_b  = AW'(l_pos);
                    state_next = ST_SCMP;
                end
            end
            ST_SCMP: begin
                wr_en   = 1'b1;
                wr_addr = AW'(cur_reg - 1'b1);
                if (child > val_reg) begin
                    wr_data    = child;
                    cur_next   = PW'(best_pos);
                    state_next = ST_SRD;
                end else begin
                    wr_data    = val_reg;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_data_reg;
                    m_flag_next  = res_flag_reg;
                    m_count_next = CNT_W'(count_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
        mem_qa_reg <= heap_mem[rd_addr_a];
        mem_qb_reg <= heap_mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        val_reg      <= val_next;
        res_data_reg <= res_data_next;
        res_flag_reg <= res_flag_next;
        m_data_reg   <= m_data_next;
        m_count_reg  <= m_count_next;
        m_flag_reg   <= m_flag_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_flag_reg;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - CNT_W){1'b0}}, m_count_reg, m_data_reg};

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= PW'(DEPTH))
        else $error("entry count above depth");

    a_delete_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_hs && s_tuser == MODE_DELETE && count_reg != '0)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("extract did not shrink the heap");

    a_sift_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SRD && count_reg != '0)
        |-> (cur_reg != '0 && cur_reg <= count_reg))
        else $error("sift position outside the heap");
`endif

endmodule
